// ===== design/pjib_pkg.sv =====
// Package for the per-joint influence bounding box block.
// Holds the transaction structs, command and state types and shared constants.
// No dependencies.
package pjib_pkg;

    // Default storage sizes for the top-level parameters.
    localparam int DEF_MAX_TARGET_JOINTS = 256;
    localparam int DEF_MAX_SKIN_JOINTS   = 256;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 17;
    localparam logic [CFG_IW-1:0] CFG_SKIN_COUNT   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_TARGET_COUNT = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_WEIGHT_THR   = 2'd2;

    localparam logic [8:0]  RST_SKIN_COUNT   = 9'd256;
    localparam logic [8:0]  RST_TARGET_COUNT = 9'd256;
    localparam logic [16:0] RST_WEIGHT_THR   = 17'd66;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_INFL = 2'd1;
    localparam logic [1:0] OP_EMIT = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PROBE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [3:0] PROBES_PER_BOX = 4'd8;
    localparam logic [2:0] LAST_CORNER    = 3'd7;

    // One input transaction.
    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         skin_joint;
        logic [7:0]         map_target;
        logic               map_valid;
        logic [16:0]        weight;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [7:0]         emit_joint;
    } t_item;

    // One result transaction.
    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         probe_count;
        logic [2:0]         corner_index;
        logic signed [31:0] corner_x;
        logic signed [31:0] corner_y;
        logic signed [31:0] corner_z;
        logic               last;
    } t_result;

    // Commands handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_ERR,
        CMD_UPD,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic [7:0]         joint;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_cmd_entry;

    // Queue fill state seen by front and back.
    typedef struct packed {
        logic            empty;
        logic [Q_CW-1:0] count;
    } t_q_stat;

    // One stored box.
    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] min_z;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
        logic signed [31:0] max_z;
    } t_box;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_UPD,
        B_EMIT
    } t_bstate;

endpackage

// ===== design/pjib_front.sv =====
// Front end: accepts transactions, holds the joint map and the configuration,
// classifies each item and pushes commands for the back end. Uses pjib_pkg.
module pjib_front #(
    parameter int MAX_TARGET_JOINTS = pjib_pkg::DEF_MAX_TARGET_JOINTS,
    parameter int MAX_SKIN_JOINTS   = pjib_pkg::DEF_MAX_SKIN_JOINTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  pjib_pkg::t_item               i_item,
    output logic                          o_busy,
    input  logic                          i_cfg_we,
    input  logic [pjib_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [pjib_pkg::CFG_DW-1:0]   i_cfg_data,
    input  pjib_pkg::t_q_stat             i_q_stat,
    output logic                          o_push,
    output pjib_pkg::t_cmd_entry          o_push_entry
);

    localparam int SAW = (MAX_SKIN_JOINTS > 1) ? $clog2(MAX_SKIN_JOINTS) : 1;
    localparam logic [12:0] SKIN_LIM   = 13'(MAX_SKIN_JOINTS);
    localparam logic [12:0] TARGET_LIM = 13'(MAX_TARGET_JOINTS);
    localparam int Q_CW_T = pjib_pkg::Q_CW;

    // Configuration registers.
    logic [8:0]  r_skin_cnt;
    logic [8:0]  r_target_cnt;
    logic [16:0] r_weight_thr;

    // Classify stage.
    logic             r_f_valid;
    pjib_pkg::t_item  r_f;
    logic [8:0]       r_map_q;
    logic [8:0]       r_map [MAX_SKIN_JOINTS];

    logic             accept;
    logic [SAW+7:0]   in_sj_ext;
    logic [SAW-1:0]   map_addr;
    logic             in_sj_ok;
    logic [Q_CW_T:0]  fill;

    // Accept when the queue has room for every item already in flight.
    assign fill   = {1'b0, i_q_stat.count} + {{Q_CW_T{1'b0}}, r_f_valid};
    assign o_busy = (fill >= (Q_CW_T + 1)'(pjib_pkg::Q_DEPTH));
    assign accept = i_start && !o_busy;

    assign in_sj_ext = {{SAW{1'b0}}, i_item.skin_joint};
    assign map_addr  = in_sj_ext[SAW-1:0];
    assign in_sj_ok  = (13'(i_item.skin_joint) < SKIN_LIM);

    // Control and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skin_cnt   <= pjib_pkg::RST_SKIN_COUNT;
            r_target_cnt <= pjib_pkg::RST_TARGET_COUNT;
            r_weight_thr <= pjib_pkg::RST_WEIGHT_THR;
            r_f_valid    <= 1'b0;
        end else begin
            r_f_valid <= accept;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pjib_pkg::CFG_SKIN_COUNT:   r_skin_cnt   <= i_cfg_data[8:0];
                    pjib_pkg::CFG_TARGET_COUNT: r_target_cnt <= i_cfg_data[8:0];
                    pjib_pkg::CFG_WEIGHT_THR:   r_weight_thr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Item capture and joint map: registered read on every accepted item, write on a map load.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f     <= i_item;
            r_map_q <= r_map[map_addr];
            if (i_item.operation == pjib_pkg::OP_LOAD && in_sj_ok) begin
                r_map[map_addr] <= i_item.map_valid ? {1'b1, i_item.map_target} : 9'd0;
            end
        end
    end

    // Classification of the held item into a back-end command.
    logic sj_bad;
    logic tgt_bad;
    logic emit_bad;

    assign sj_bad   = ({1'b0, r_f.skin_joint} >= r_skin_cnt)
                   || (13'(r_f.skin_joint) >= SKIN_LIM);
    assign tgt_bad  = ({1'b0, r_map_q[7:0]} >= r_target_cnt)
                   || (13'(r_map_q[7:0]) >= TARGET_LIM);
    assign emit_bad = ({1'b0, r_f.emit_joint} >= r_target_cnt)
                   || (13'(r_f.emit_joint) >= TARGET_LIM);

    always_comb begin
        o_push             = 1'b0;
        o_push_entry.cmd   = pjib_pkg::CMD_ERR;
        o_push_entry.joint = r_f.skin_joint;
        o_push_entry.pos_x = r_f.pos_x;
        o_push_entry.pos_y = r_f.pos_y;
        o_push_entry.pos_z = r_f.pos_z;
        if (r_f_valid) begin
            case (r_f.operation)
                pjib_pkg::OP_INFL: begin
                    if (r_f.weight > r_weight_thr) begin
                        if (sj_bad) begin
                            o_push = 1'b1;
                        end else if (r_map_q[8] && !tgt_bad) begin
                            o_push             = 1'b1;
                            o_push_entry.cmd   = pjib_pkg::CMD_UPD;
                            o_push_entry.joint = r_map_q[7:0];
                        end
                    end
                end
                pjib_pkg::OP_EMIT: begin
                    o_push             = 1'b1;
                    o_push_entry.joint = r_f.emit_joint;
                    if (!emit_bad) begin
                        o_push_entry.cmd = pjib_pkg::CMD_EMIT;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== design/pjib_queue.sv =====
// Short command queue between front and back end.
// Uses the command entry and status types of pjib_pkg.
module pjib_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  pjib_pkg::t_cmd_entry  i_push_entry,
    input  logic                  i_pop,
    output pjib_pkg::t_cmd_entry  o_head,
    output pjib_pkg::t_q_stat     o_stat
);

    pjib_pkg::t_cmd_entry            r_mem [pjib_pkg::Q_DEPTH];
    logic [pjib_pkg::Q_AW-1:0]       r_wr_ptr;
    logic [pjib_pkg::Q_AW-1:0]       r_rd_ptr;
    logic [pjib_pkg::Q_CW-1:0]       r_count;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == pjib_pkg::Q_AW'(pjib_pkg::Q_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == pjib_pkg::Q_AW'(pjib_pkg::Q_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// ===== design/pjib_back.sv =====
// Back end: box memory, influenced bits and the result sequencer.
// Widens or seeds boxes and emits corners; uses pjib_pkg.
module pjib_back #(
    parameter int MAX_TARGET_JOINTS = pjib_pkg::DEF_MAX_TARGET_JOINTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pjib_pkg::t_cmd_entry  i_head,
    input  pjib_pkg::t_q_stat     i_q_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    output pjib_pkg::t_result     o_result
);

    localparam int TAW = (MAX_TARGET_JOINTS > 1) ? $clog2(MAX_TARGET_JOINTS) : 1;

    pjib_pkg::t_bstate    r_state;
    pjib_pkg::t_bstate    n_state;
    logic [2:0]           r_cnt;
    pjib_pkg::t_cmd_entry r_cmd;
    logic [TAW-1:0]       r_addr;
    logic [MAX_TARGET_JOINTS-1:0] r_influenced;
    pjib_pkg::t_box       r_box [MAX_TARGET_JOINTS];
    pjib_pkg::t_box       r_rd;
    logic                 r_valid;
    logic                 n_valid;
    pjib_pkg::t_result    r_result;
    pjib_pkg::t_result    n_result;

    logic [TAW+7:0]       head_ext;
    logic [TAW-1:0]       head_addr;
    logic                 head_infl;
    logic                 box_we;
    pjib_pkg::t_box       box_new;

    assign head_ext  = {{TAW{1'b0}}, i_head.joint};
    assign head_addr = head_ext[TAW-1:0];
    assign head_infl = r_influenced[head_addr];
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pjib_pkg::B_IDLE: begin
                if (!i_q_stat.empty) begin
                    if (i_head.cmd == pjib_pkg::CMD_UPD) begin
                        n_state = pjib_pkg::B_UPD;
                    end else if (i_head.cmd == pjib_pkg::CMD_EMIT && head_infl) begin
                        n_state = pjib_pkg::B_EMIT;
                    end
                end
            end
            pjib_pkg::B_UPD: n_state = pjib_pkg::B_IDLE;
            pjib_pkg::B_EMIT: begin
                if (r_cnt == pjib_pkg::LAST_CORNER) begin
                    n_state = pjib_pkg::B_IDLE;
                end
            end
            default: n_state = pjib_pkg::B_IDLE;
        endcase
    end

    // Outputs of the sequencer: queue pop, box write and the next result.
    always_comb begin
        o_pop                 = 1'b0;
        box_we                = 1'b0;
        n_valid               = 1'b0;
        n_result.status       = pjib_pkg::ST_OK;
        n_result.probe_count  = 4'd0;
        n_result.corner_index = 3'd0;
        n_result.corner_x     = '0;
        n_result.corner_y     = '0;
        n_result.corner_z     = '0;
        n_result.last         = 1'b1;
        unique case (r_state)
            pjib_pkg::B_IDLE: begin
                o_pop = !i_q_stat.empty;
                if (!i_q_stat.empty) begin
                    if (i_head.cmd == pjib_pkg::CMD_ERR) begin
                        n_valid         = 1'b1;
                        n_result.status = pjib_pkg::ST_RANGE;
                    end else if (i_head.cmd == pjib_pkg::CMD_EMIT && !head_infl) begin
                        n_valid         = 1'b1;
                        n_result.status = pjib_pkg::ST_NO_PROBE;
                    end
                end
            end
            pjib_pkg::B_UPD: box_we = 1'b1;
            pjib_pkg::B_EMIT: begin
                n_valid               = 1'b1;
                n_result.probe_count  = pjib_pkg::PROBES_PER_BOX;
                n_result.corner_index = r_cnt;
                n_result.corner_x     = r_cnt[2] ? r_rd.max_x : r_rd.min_x;
                n_result.corner_y     = r_cnt[1] ? r_rd.max_y : r_rd.min_y;
                n_result.corner_z     = r_cnt[0] ? r_rd.max_z : r_rd.min_z;
                n_result.last         = (r_cnt == pjib_pkg::LAST_CORNER);
            end
            default: ;
        endcase
    end

    // New box: seed on the first influence, otherwise widen per axis.
    always_comb begin
        if (!r_influenced[r_addr]) begin
            box_new.min_x = r_cmd.pos_x;
            box_new.max_x = r_cmd.pos_x;
            box_new.min_y = r_cmd.pos_y;
            box_new.max_y = r_cmd.pos_y;
            box_new.min_z = r_cmd.pos_z;
            box_new.max_z = r_cmd.pos_z;
        end else begin
            box_new.min_x = (r_cmd.pos_x < r_rd.min_x) ? r_cmd.pos_x : r_rd.min_x;
            box_new.max_x = (r_cmd.pos_x > r_rd.max_x) ? r_cmd.pos_x : r_rd.max_x;
            box_new.min_y = (r_cmd.pos_y < r_rd.min_y) ? r_cmd.pos_y : r_rd.min_y;
            box_new.max_y = (r_cmd.pos_y > r_rd.max_y) ? r_cmd.pos_y : r_rd.max_y;
            box_new.min_z = (r_cmd.pos_z < r_rd.min_z) ? r_cmd.pos_z : r_rd.min_z;
            box_new.max_z = (r_cmd.pos_z > r_rd.max_z) ? r_cmd.pos_z : r_rd.max_z;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pjib_pkg::B_IDLE;
            r_cnt        <= 3'd0;
            r_valid      <= 1'b0;
            r_influenced <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_cnt   <= (r_state == pjib_pkg::B_EMIT) ? r_cnt + 3'd1 : 3'd0;
            if (box_we) begin
                r_influenced[r_addr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (o_pop) begin
            r_cmd  <= i_head;
            r_addr <= head_addr;
        end
    end

    // Box memory: read on a pop, write back after an update.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_box[head_addr];
        end
        if (box_we) begin
            r_box[r_addr] <= box_new;
        end
    end

endmodule

// ===== design/per_joint_influence_bounding_box.sv =====
// Top level of the per-joint influence bounding box block.
// Joins front end, command queue and back end; depends on pjib_pkg and all pjib_ modules.
//
// Usage:
//   Input transactions enter on i_item and are accepted at a clock edge with start high
//   and busy low. Map loads write the joint map, influences seed or widen one target
//   joint's box, emits read back its eight corners (or one status result).
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
//   Results appear on o_result for exactly one cycle each, marked by o_valid; the
//   receiver cannot stall them.
// Timing:
//   The front end takes one transaction per cycle while the four-entry command queue
//   has room. The back end answers an error or no-probe command straight from idle, handles
//   a box update as a read then a write of the box memory and an emit as one read, then
//   one corner per cycle. Loads and dropped items cost no back-end time.
//   A result passes the held item register, the command queue and the result register;
//   an emit also passes the box read register. Corners follow in consecutive cycles.
// Reset:
//   Synchronous, active low. Configuration returns to its defaults and all joints read
//   as uninfluenced at once; no clearing pass is needed.
module per_joint_influence_bounding_box #(
    parameter int MAX_TARGET_JOINTS = pjib_pkg::DEF_MAX_TARGET_JOINTS,
    parameter int MAX_SKIN_JOINTS   = pjib_pkg::DEF_MAX_SKIN_JOINTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  pjib_pkg::t_item               i_item,
    input  logic                          i_cfg_we,
    input  logic [pjib_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [pjib_pkg::CFG_DW-1:0]   i_cfg_data,
    output logic                          o_valid,
    output pjib_pkg::t_result             o_result
);

    logic                 push;
    pjib_pkg::t_cmd_entry push_entry;
    logic                 pop;
    pjib_pkg::t_cmd_entry head;
    pjib_pkg::t_q_stat    q_stat;

    // Front end: acceptance and classification.
    pjib_front #(
        .MAX_TARGET_JOINTS (MAX_TARGET_JOINTS),
        .MAX_SKIN_JOINTS   (MAX_SKIN_JOINTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_item       (i_item),
        .o_busy       (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    // Command queue.
    pjib_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_stat       (q_stat)
    );

    // Back end: box storage and result sequencing.
    pjib_back #(
        .MAX_TARGET_JOINTS (MAX_TARGET_JOINTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
